// File: design/prescaled_timer_with_reload_assert.svh
// Assertion macros for the prescaled timer with reload.
`ifndef PRESCALED_TIMER_WITH_RELOAD_ASSERT_SVH
`define PRESCALED_TIMER_WITH_RELOAD_ASSERT_SVH
`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define PTWR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("timer assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define PTWR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("timer assertion failed");
`else
`define PTWR_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define PTWR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: design/ptwr_pkg.sv
// Shared types, constants and functions of the prescaled timer with reload.
package ptwr_pkg;

	localparam int CYCLE_BITS = 16;
	localparam int CYC_W      = 16;
	localparam logic [CYC_W-1:0] CYC_MASK =
		(CYCLE_BITS >= CYC_W) ? {CYC_W{1'b1}} : CYC_W'((1 << CYCLE_BITS) - 1);

	localparam int SUM_W     = CYC_W + 1;
	localparam int MIN_SHIFT = 4;
	localparam int EDGE_W    = SUM_W - MIN_SHIFT;

	localparam int ENABLE_BIT = 2;
	localparam logic [29:0] DISABLED_DIST = 30'h3FFF_FFFF;
	localparam logic [7:0]  COUNT_TOP     = 8'hFF;

	localparam logic CMD_ADVANCE = 1'b0;
	localparam logic CMD_LOAD    = 1'b1;

	localparam logic CFG_CONTROL = 1'b0;
	localparam logic CFG_RELOAD  = 1'b1;

	typedef struct packed {
		logic        cmd;
		logic [15:0] cycle_count;
		logic [15:0] load_divider;
		logic [7:0]  load_count;
	} ptwr_req_t;

	typedef struct packed {
		logic [7:0]  divider_high;
		logic [7:0]  timer_count;
		logic        timer_irq;
		logic [29:0] cycles_to_overflow;
	} ptwr_res_t;

	typedef struct packed {
		logic [2:0] timer_control;
		logic [7:0] reload_value;
	} ptwr_cfg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} ptwr_stat_t;

	// Prescaler period as a power of two, by select: shifts of 10, 4, 6 and 8.
	function automatic logic [3:0] period_shift(input logic [1:0] sel);
		logic [3:0] sh;
		case (sel)
			2'd0:    sh = 4'd10;
			2'd1:    sh = 4'd4;
			2'd2:    sh = 4'd6;
			2'd3:    sh = 4'd8;
			default: sh = 4'd10;
		endcase
		return sh;
	endfunction

endpackage

// File: design/ptwr_core.sv
// Sequencer and datapath that loads or advances the divider and walks the timer edges.
module ptwr_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  ptwr_pkg::ptwr_req_t   req,
	input  ptwr_pkg::ptwr_cfg_t   cfg,
	input  logic                  out_free,
	output ptwr_pkg::ptwr_stat_t  stat,
	output ptwr_pkg::ptwr_res_t   res
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EDGES,
		ST_WALK,
		ST_DIST
	} state_t;

	state_t                          state_q;
	logic [15:0]                     divider_q;
	logic [7:0]                      count_q;
	logic [ptwr_pkg::SUM_W-1:0]      after_q;
	logic [ptwr_pkg::EDGE_W-1:0]     edges_q;
	logic                            irq_q;

	logic        enabled;
	logic [3:0]  sh;
	logic [10:0] period;
	logic [10:0] to_edge;
	logic [17:0] span;
	logic [18:0] dist_sum;

	assign enabled = cfg.timer_control[ptwr_pkg::ENABLE_BIT];
	assign sh      = ptwr_pkg::period_shift(cfg.timer_control[1:0]);

	// Cycles to the next prescaler edge plus full periods for the remaining increments.
	assign period   = 11'(1) << sh;
	assign to_edge  = period - (divider_q[10:0] & (period - 11'd1));
	assign span     = {10'd0, 8'(ptwr_pkg::COUNT_TOP - count_q)} << sh;
	assign dist_sum = 19'(span) + 19'(to_edge);

	always_comb begin
		res.divider_high       = divider_q[15:8];
		res.timer_count        = count_q;
		res.timer_irq          = irq_q;
		res.cycles_to_overflow = enabled ? 30'(dist_sum) : ptwr_pkg::DISABLED_DIST;
	end

	assign stat.busy = (state_q != ST_IDLE);
	assign stat.done = (state_q == ST_DIST) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			divider_q <= '0;
			count_q   <= '0;
			after_q   <= '0;
			edges_q   <= '0;
			irq_q     <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						irq_q <= 1'b0;
						if (req.cmd == ptwr_pkg::CMD_LOAD) begin
							divider_q <= req.load_divider;
							count_q   <= req.load_count;
							state_q   <= ST_DIST;
						end else begin
							after_q <= {1'b0, divider_q}
								+ {1'b0, req.cycle_count & ptwr_pkg::CYC_MASK};
							state_q <= ST_EDGES;
						end
					end
				end
				ST_EDGES: begin
					// Edges are counted on the unwrapped sum so a crossing at the wrap is seen.
					divider_q <= after_q[15:0];
					if (enabled) begin
						edges_q <= ptwr_pkg::EDGE_W'(after_q >> sh)
							- ptwr_pkg::EDGE_W'({1'b0, divider_q} >> sh);
					end else begin
						edges_q <= '0;
					end
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (edges_q == '0) begin
						state_q <= ST_DIST;
					end else begin
						edges_q <= edges_q - ptwr_pkg::EDGE_W'(1);
						if (count_q == ptwr_pkg::COUNT_TOP) begin
							count_q <= cfg.reload_value;
							irq_q   <= 1'b1;
						end else begin
							count_q <= count_q + 8'd1;
						end
					end
				end
				ST_DIST: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: design/prescaled_timer_with_reload.sv
// Top level of the prescaled timer with reload: ports, registers and result buffer.
//
//  Channel  Direction  Handshake                 Contents
//  s_*      in         s_tvalid / s_tready       timer command (advance or load)
//  m_*      out        m_tvalid / m_tready       divider, count, overflow flag, distance
//  cfg_*    in         cfg_valid / cfg_ready     register index and write data
//
// An advance passes the EDGES, WALK and DIST states, the count being stepped one edge per
// cycle in WALK by a single incrementer; a load goes from IDLE straight to DIST.
// The result waits in an output register while the next command is being worked on.
// Reset clears the divider, the count and both registers.
// The command side is stalled while a command is in progress.
`include "prescaled_timer_with_reload_assert.svh"
module prescaled_timer_with_reload (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // cycle_count[15:0], load_divider[31:16], load_count[39:32]
	input  logic        s_tuser,  // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // divider_high[7:0], timer_count[15:8], timer_irq[16],
	                              // cycles_to_overflow[46:17], zero[47]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);

	ptwr_pkg::ptwr_req_t  req;
	ptwr_pkg::ptwr_cfg_t  cfg_q;
	ptwr_pkg::ptwr_stat_t stat;
	ptwr_pkg::ptwr_res_t  res;

	logic        start;
	logic        out_free;
	logic        m_tvalid_q;
	logic [47:0] m_tdata_q;

	assign req.cmd          = s_tuser;
	assign req.cycle_count  = s_tdata[15:0];
	assign req.load_divider = s_tdata[31:16];
	assign req.load_count   = s_tdata[39:32];

	assign s_tready  = !stat.busy;
	assign start     = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	ptwr_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (req),
		.cfg      (cfg_q),
		.out_free (out_free),
		.stat     (stat),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				ptwr_pkg::CFG_CONTROL: cfg_q.timer_control <= cfg_data[2:0];
				ptwr_pkg::CFG_RELOAD:  cfg_q.reload_value  <= cfg_data;
				default:               cfg_q <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (stat.done) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done) begin
			m_tdata_q <= {1'b0, res.cycles_to_overflow, res.timer_irq,
				res.timer_count, res.divider_high};
		end
	end

	// A new result is only written when the buffer is empty or being drained.
	`PTWR_ASSERT_SAME(a_no_overwrite, clk, arst_n, stat.done, (!m_tvalid_q || m_tready))
	// An accepted command always occupies the sequencer in the next cycle.
	`PTWR_ASSERT_NEXT(a_busy_after_start, clk, arst_n, start, stat.busy)
	// A completed command leaves a result pending in the next cycle.
	`PTWR_ASSERT_NEXT(a_result_after_done, clk, arst_n, stat.done, m_tvalid_q)

endmodule

// File: test/tb_top.sv
// Self-checking testbench for the prescaled timer with reload: directed, random and backpressure tests.
`timescale 1ns / 1ps
module tb_top;

	localparam int unsigned SHIFT_OF_SELECT [4] = '{10, 4, 6, 8};
	localparam int IDLE_LIMIT   = 20000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASE_ITEMS  = 140;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata   = '0;  // cycle_count[15:0], load_divider[31:16], load_count[39:32]
	logic        s_tuser   = ptwr_pkg::CMD_ADVANCE;  // cmd
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [47:0] m_tdata;  // divider_high[7:0], timer_count[15:8], timer_irq[16],
	                       // cycles_to_overflow[46:17], zero[47]
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = ptwr_pkg::CFG_CONTROL;
	logic [7:0]  cfg_data  = '0;

	// Predicted state of the timer and its registers.
	logic [15:0] model_divider = '0;
	logic [7:0]  model_count   = '0;
	logic [2:0]  model_control = '0;
	logic [7:0]  model_reload  = '0;

	ptwr_pkg::ptwr_res_t pending_results [$];
	int        mismatches = 0;
	int        idle_cycles = 0;
	bit        quiet = 1'b0;
	bit        hold_start = 1'b0;
	int        hold_left = 0;
	int        stall_left = 0;

	prescaled_timer_with_reload u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Applies one command to the predicted state and returns the result it should produce.
	function automatic ptwr_pkg::ptwr_res_t step_timer(input logic cmd, input logic [15:0] cyc,
			input logic [15:0] div, input logic [7:0] cnt);
		ptwr_pkg::ptwr_res_t res;
		int unsigned shift, start, stop, edges, first, span, period, to_edge;
		res.timer_irq = 1'b0;
		shift = SHIFT_OF_SELECT[model_control[1:0]];
		if (cmd == ptwr_pkg::CMD_LOAD) begin
			model_divider = div;
			model_count   = cnt;
		end else begin
			start = model_divider;
			stop  = start + (cyc & ptwr_pkg::CYC_MASK);
			model_divider = 16'(stop);
			if (model_control[ptwr_pkg::ENABLE_BIT]) begin
				// Edges are counted on the unwrapped sum, so a wrap still counts its boundary.
				edges = (stop >> shift) - (start >> shift);
				first = 256 - model_count;
				if (edges < first) begin
					model_count = 8'(model_count + edges);
				end else begin
					res.timer_irq = 1'b1;
					span = 256 - model_reload;
					model_count = 8'(model_reload + (edges - first) % span);
				end
			end
		end
		res.divider_high = model_divider[15:8];
		res.timer_count  = model_count;
		if (model_control[ptwr_pkg::ENABLE_BIT]) begin
			period  = 1 << shift;
			to_edge = period - (model_divider & (period - 1));
			res.cycles_to_overflow = 30'(to_edge + (255 - model_count) * period);
		end else begin
			res.cycles_to_overflow = ptwr_pkg::DISABLED_DIST;
		end
		return res;
	endfunction

	task automatic send_command(input logic cmd, input logic [15:0] cyc,
			input logic [15:0] div, input logic [7:0] cnt);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		repeat (gap) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tuser  <= cmd;
		s_tdata  <= {cnt, div, cyc};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(step_timer(cmd, cyc, div, cnt));
	endtask

	task automatic write_register(input logic idx, input logic [7:0] data);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		if (idx == ptwr_pkg::CFG_CONTROL)
			model_control = data[2:0];
		else
			model_reload = data;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic test_directed_cases();
		// Reset state, zero cycles, and a disabled timer whose divider still moves and wraps.
		send_command(ptwr_pkg::CMD_ADVANCE, 16'h0000, 16'($urandom), 8'($urandom));
		send_command(ptwr_pkg::CMD_ADVANCE, 16'hFFFF, 16'($urandom), 8'($urandom));
		send_command(ptwr_pkg::CMD_LOAD, 16'($urandom), 16'hFFFF, 8'hFF);
		send_command(ptwr_pkg::CMD_ADVANCE, 16'h0001, 16'h0000, 8'h00);
		wait_idle();
		// Period 16 with reload at its top: a boundary crossed at the wrap, then overflows.
		write_register(ptwr_pkg::CFG_CONTROL, 8'h05);
		write_register(ptwr_pkg::CFG_RELOAD, 8'hFF);
		send_command(ptwr_pkg::CMD_LOAD, 16'hFFFF, 16'hFFF8, 8'hFE);
		send_command(ptwr_pkg::CMD_ADVANCE, 16'h0010, 16'($urandom), 8'($urandom));
		send_command(ptwr_pkg::CMD_ADVANCE, 16'h0010, 16'($urandom), 8'($urandom));
		send_command(ptwr_pkg::CMD_ADVANCE, 16'hFFFF, 16'($urandom), 8'($urandom));
		wait_idle();
		// Period 256 with reload zero, and a zero-cycle step while enabled.
		write_register(ptwr_pkg::CFG_CONTROL, 8'hFF);
		write_register(ptwr_pkg::CFG_RELOAD, 8'h00);
		send_command(ptwr_pkg::CMD_ADVANCE, 16'hFFFF, 16'($urandom), 8'($urandom));
		send_command(ptwr_pkg::CMD_LOAD, 16'($urandom), 16'h00FF, 8'h00);
		send_command(ptwr_pkg::CMD_ADVANCE, 16'h0001, 16'($urandom), 8'($urandom));
		send_command(ptwr_pkg::CMD_ADVANCE, 16'h0000, 16'($urandom), 8'($urandom));
		wait_idle();
		// Period 1024: a single edge at the top of the count, then a long run from zero.
		write_register(ptwr_pkg::CFG_CONTROL, 8'h04);
		write_register(ptwr_pkg::CFG_RELOAD, 8'hA5);
		send_command(ptwr_pkg::CMD_LOAD, 16'h0000, 16'h03FF, 8'hFF);
		send_command(ptwr_pkg::CMD_ADVANCE, 16'h0001, 16'hFFFF, 8'hFF);
		send_command(ptwr_pkg::CMD_LOAD, 16'hFFFF, 16'h0000, 8'h00);
		send_command(ptwr_pkg::CMD_ADVANCE, 16'hFFFF, 16'($urandom), 8'($urandom));
		wait_idle();
		// Period 64: many overflows in one step, so the count wraps through the reload span.
		write_register(ptwr_pkg::CFG_CONTROL, 8'h06);
		write_register(ptwr_pkg::CFG_RELOAD, 8'h80);
		send_command(ptwr_pkg::CMD_LOAD, 16'($urandom), 16'h0000, 8'hC0);
		send_command(ptwr_pkg::CMD_ADVANCE, 16'hFFFF, 16'($urandom), 8'($urandom));
		wait_idle();
	endtask

	function automatic logic [15:0] pick_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (r < 2)
			return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
		if (r < 5)
			return 16'($urandom);
		if (r < 30)
			return 16'($urandom_range(0, 4095));
		return 16'($urandom_range(0, 300));
	endfunction

	task automatic send_random_items(input int count);
		logic [7:0] cnt;
		logic       cmd;
		repeat (count) begin
			cmd = ($urandom_range(0, 7) == 0) ? ptwr_pkg::CMD_LOAD : ptwr_pkg::CMD_ADVANCE;
			cnt = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(8'hF0, 8'hFF)) : 8'($urandom);
			send_command(cmd, pick_cycles(), 16'($urandom), cnt);
		end
	endtask

	task automatic test_random_phases();
		logic [7:0] control, reload;
		for (int phase = 0; phase < 11; phase++) begin
			control = (phase < 8) ? 8'(phase) : 8'($urandom_range(4, 7));
			case (phase % 4)
				0:       reload = 8'h00;
				1:       reload = 8'hFF;
				2:       reload = 8'($urandom_range(8'hE0, 8'hFE));
				default: reload = 8'($urandom);
			endcase
			// The upper bits of the control write are ignored by the block.
			control[7:3] = 5'($urandom);
			write_register(ptwr_pkg::CFG_CONTROL, control);
			write_register(ptwr_pkg::CFG_RELOAD, reload);
			quiet = (phase == 5);
			send_random_items(PHASE_ITEMS);
			wait_idle();
		end
		quiet = 1'b0;
	endtask

	task automatic test_output_backpressure();
		write_register(ptwr_pkg::CFG_CONTROL, 8'h05);
		write_register(ptwr_pkg::CFG_RELOAD, 8'($urandom_range(8'hC0, 8'hFF)));
		quiet = 1'b1;
		hold_start = 1'b1;
		send_random_items(30);
		quiet = 1'b0;
		send_random_items(30);
		wait_idle();
	endtask

	// Result side: random stalls, plus one long hold-off on request.
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_start || hold_left > 0) begin
			if (hold_start) begin
				hold_start = 1'b0;
				hold_left  = HOLD_CYCLES;
			end
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left = stall_left - 1;
			m_tready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			stall_left = pick_gap();
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic check_field(input string name, input longint unsigned expected_value,
			input longint unsigned actual_value);
		if (expected_value != actual_value) begin
			$error("%s: expected %0d, got %0d", name, expected_value, actual_value);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		ptwr_pkg::ptwr_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("result transfer with no command outstanding");
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_field("divider_high", want.divider_high, m_tdata[7:0]);
				check_field("timer_count", want.timer_count, m_tdata[15:8]);
				check_field("timer_irq", want.timer_irq, m_tdata[16]);
				check_field("cycles_to_overflow", want.cycles_to_overflow, m_tdata[46:17]);
			end
		end
	end

	// Ends the run if no transfer of any kind happens for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("prescaled_timer_with_reload test failed");
				$finish;
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed_cases();
		test_random_phases();
		test_output_backpressure();
		wait_idle();
		if (mismatches == 0)
			$display("prescaled_timer_with_reload test passed");
		else
			$display("prescaled_timer_with_reload test failed");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+design
design/ptwr_pkg.sv
design/ptwr_core.sv
design/prescaled_timer_with_reload.sv
test/tb_top.sv
